### rtl/eupd_pkg.sv
// Shared types, codes and the operator rule table of the encoded user path decoder.
// Stands alone; used by encoded_user_path_decoder_unit through scoped names.

package eupd_pkg;

   localparam int OPERAND_LIMIT = 65536;
   localparam int IDX_W         = $clog2(OPERAND_LIMIT + 1);
   localparam int NEED_W        = 11;
   localparam int START_W       = 16;
   localparam int SUM_MAX_W     = (IDX_W > NEED_W) ? IDX_W : NEED_W;
   localparam int SUM_W         = ((SUM_MAX_W > START_W) ? SUM_MAX_W : START_W) + 1;

   localparam logic [7:0] REPEAT_BASE = 8'd32;
   localparam logic [7:0] MAX_OP      = 8'd11;

   localparam logic [3:0] OP_SETBBOX   = 4'd0;
   localparam logic [3:0] OP_MOVETO    = 4'd1;
   localparam logic [3:0] OP_RMOVETO   = 4'd2;
   localparam logic [3:0] OP_LINETO    = 4'd3;
   localparam logic [3:0] OP_RLINETO   = 4'd4;
   localparam logic [3:0] OP_CURVETO   = 4'd5;
   localparam logic [3:0] OP_RCURVETO  = 4'd6;
   localparam logic [3:0] OP_ARC       = 4'd7;
   localparam logic [3:0] OP_ARCN      = 4'd8;
   localparam logic [3:0] OP_ARCT      = 4'd9;
   localparam logic [3:0] OP_CLOSEPATH = 4'd10;
   localparam logic [3:0] OP_UCACHE    = 4'd11;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_ORDER    = 3'd2;
   localparam logic [2:0] ST_NO_BBOX  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [2:0] {
      PH_INITIAL = 3'b001,
      PH_UCACHE  = 3'b010,
      PH_PATH    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [2:0] nargs;
      logic [2:0] allowed;   // phase mask, same one-hot codes as phase_type
      phase_type  next;
   } op_rule_type;

   function automatic op_rule_type op_rule(input logic [3:0] code);
      op_rule_type r;
      r = '{nargs: 3'd0, allowed: 3'b000, next: PH_INITIAL};
      unique case (code)
         OP_SETBBOX: r = '{nargs: 3'd4, allowed: 3'b011, next: PH_PATH};
         OP_MOVETO, OP_RMOVETO, OP_LINETO, OP_RLINETO:
            r = '{nargs: 3'd2, allowed: 3'b100, next: PH_PATH};
         OP_CURVETO, OP_RCURVETO:
            r = '{nargs: 3'd6, allowed: 3'b100, next: PH_PATH};
         OP_ARC, OP_ARCN, OP_ARCT:
            r = '{nargs: 3'd5, allowed: 3'b100, next: PH_PATH};
         OP_CLOSEPATH: r = '{nargs: 3'd0, allowed: 3'b100, next: PH_PATH};
         OP_UCACHE:    r = '{nargs: 3'd0, allowed: 3'b001, next: PH_UCACHE};
         default:      r = '{nargs: 3'd0, allowed: 3'b000, next: PH_INITIAL};
      endcase
      return r;
   endfunction

endpackage

### rtl/encoded_user_path_decoder_unit.sv
// Encoded user path operator decoder: one result per input byte.
// Depends on eupd_pkg for codes, widths and the operator rule table.
//
//   channel  | direction | tdata                        | tuser        | tlast
//   req_     | in        | [7:0] op_byte                | -            | last_byte
//   rsp_     | out       | code, nargs, repeat, start,  | is_operator  | path_done
//            |           | status (see port comment)    |              |
//   csr_     | in        | csr_wr_data: compat_mode     | -            | -
//
// One byte per cycle sustained while rsp_tready is held high; each byte passes the
// input register, then the result register, with the decode and index add between.
// Reset (synchronous) clears compat_mode, the phase, repeat, index and error.
// A stalled result holds in the result register while the input register still
// takes one more byte; req_tready drops only when both are full.

module encoded_user_path_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // compat_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] op_byte
   input  logic        req_tlast,     // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [3:0] operator_code, [6:4] arg_count,
                                      // [14:7] repeat_count, [30:15] operand_start,
                                      // [33:31] status, [39:34] zero
   output logic        rsp_tuser,     // is_operator
   output logic        rsp_tlast      // path_done
);

   logic compat_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   eupd_pkg::phase_type               phase_ff, phase_in;
   logic [7:0]                        pend_ff, pend_in;
   logic [eupd_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic                              err_ff, err_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_isop_ff, rsp_isop_in;
   logic [3:0]                        rsp_code_ff, rsp_code_in;
   logic [2:0]                        rsp_nargs_ff, rsp_nargs_in;
   logic [7:0]                        rsp_rep_ff, rsp_rep_in;
   logic [eupd_pkg::START_W-1:0]      rsp_start_ff, rsp_start_in;
   logic [2:0]                        rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff;

   logic                              adv;
   logic                              ok;
   eupd_pkg::op_rule_type             rule;
   logic [eupd_pkg::NEED_W-1:0]       need;
   logic [eupd_pkg::SUM_W-1:0]        idx_wide;
   logic [eupd_pkg::SUM_W-1:0]        sum;

   // advance the input register into the result register
   assign adv          = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || adv;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !adv);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp_tready);

   assign rule     = eupd_pkg::op_rule(in_byte_ff[3:0]);
   assign need     = eupd_pkg::NEED_W'(rule.nargs) * eupd_pkg::NEED_W'(pend_ff);
   assign idx_wide = eupd_pkg::SUM_W'(idx_ff);
   assign sum      = idx_wide + eupd_pkg::SUM_W'(need);

   always_comb begin
      phase_in      = phase_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      err_in        = err_ff;
      ok            = 1'b1;
      rsp_isop_in   = 1'b0;
      rsp_code_in   = '0;
      rsp_nargs_in  = '0;
      rsp_rep_in    = '0;
      rsp_start_in  = '0;
      rsp_status_in = eupd_pkg::ST_OK;
      if (!err_ff) begin
         if (in_byte_ff > eupd_pkg::REPEAT_BASE) begin
            pend_in = in_byte_ff - eupd_pkg::REPEAT_BASE;
         end else if (in_byte_ff > eupd_pkg::MAX_OP) begin
            rsp_status_in = eupd_pkg::ST_INVALID;
            err_in        = 1'b1;
         end else begin
            rsp_code_in  = in_byte_ff[3:0];
            rsp_nargs_in = rule.nargs;
            rsp_rep_in   = pend_ff;
            rsp_start_in = idx_wide[eupd_pkg::START_W-1:0];
            if (compat_ff && in_byte_ff[3:0] == eupd_pkg::OP_UCACHE) begin
               phase_in = (phase_ff == eupd_pkg::PH_PATH) ? eupd_pkg::PH_PATH
                                                          : eupd_pkg::PH_UCACHE;
            end else if ((rule.allowed & phase_ff) == 3'b000) begin
               ok            = 1'b0;
               rsp_status_in = eupd_pkg::ST_ORDER;
               err_in        = 1'b1;
            end else begin
               phase_in = rule.next;
            end
            if (ok) begin
               if (sum > eupd_pkg::SUM_W'(eupd_pkg::OPERAND_LIMIT)) begin
                  // saturate the index and latch the overflow
                  idx_in        = eupd_pkg::IDX_W'(eupd_pkg::OPERAND_LIMIT);
                  rsp_status_in = eupd_pkg::ST_OVERFLOW;
                  err_in        = 1'b1;
               end else begin
                  idx_in      = sum[eupd_pkg::IDX_W-1:0];
                  rsp_isop_in = 1'b1;
               end
            end
            pend_in = 8'd1;
         end
         if (in_last_ff && !err_in && phase_in != eupd_pkg::PH_PATH) begin
            rsp_status_in = eupd_pkg::ST_NO_BBOX;
         end
      end
      if (in_last_ff) begin
         phase_in = eupd_pkg::PH_INITIAL;
         pend_in  = 8'd1;
         idx_in   = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compat_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= eupd_pkg::PH_INITIAL;
         pend_ff      <= 8'd1;
         idx_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            compat_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            phase_ff <= phase_in;
            pend_ff  <= pend_in;
            idx_ff   <= idx_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (adv) begin
         rsp_isop_ff   <= rsp_isop_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_nargs_ff  <= rsp_nargs_in;
         rsp_rep_ff    <= rsp_rep_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_status_ff, rsp_start_ff, rsp_rep_ff,
                        rsp_nargs_ff, rsp_code_ff};
   assign rsp_tuser  = rsp_isop_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a latched error silences every later byte
   assert property (@(posedge clock) disable iff (reset)
      (adv && err_ff) |=> (!rsp_isop_ff && rsp_status_ff == eupd_pkg::ST_OK))
      else $error("byte issued while error latched");

   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= eupd_pkg::IDX_W'(eupd_pkg::OPERAND_LIMIT))
      else $error("operand index beyond limit");

   assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> (pend_ff == 8'd1 && idx_ff == '0 && !err_ff
                               && phase_ff == eupd_pkg::PH_INITIAL && rsp_last_ff))
      else $error("state not cleared after last byte");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff != 8'd0)
      else $error("repeat count zero");

endmodule
